/* rtl/last_heard_mru_table_core_macros.svh */
// Assertion macros shared by the checker.
`ifndef LAST_HEARD_MRU_TABLE_CORE_MACROS_SVH
`define LAST_HEARD_MRU_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LHMRU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LHMRU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lhmru_pkg.sv */
`timescale 1ns / 1ps

package lhmru_pkg;

    // Field widths
    localparam int OP_W      = 8;
    localparam int PAYLOAD_W = 56;
    localparam int ID_W      = 24;
    localparam int TG_W      = 24;
    localparam int IDTG_W    = ID_W + TG_W;
    localparam int ALIAS_LEN = 32;
    localparam int ROW_W     = ALIAS_LEN * 8;

    // Stream widths
    localparam int S_DATA_W  = PAYLOAD_W;
    localparam int S_USER_W  = OP_W;
    localparam int M_DATA_W  = ID_W + TG_W + ROW_W;
    localparam int M_USER_W  = 2;

    // Frame opcodes
    localparam logic [OP_W-1:0] OP_VOICE_HDR = 8'h00;
    localparam logic [OP_W-1:0] OP_ALIAS_0   = 8'h04;
    localparam logic [OP_W-1:0] OP_ALIAS_1   = 8'h05;
    localparam logic [OP_W-1:0] OP_ALIAS_2   = 8'h06;
    localparam logic [OP_W-1:0] OP_ALIAS_3   = 8'h07;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [TG_W-1:0]   tg_t;
    typedef logic [ROW_W-1:0]  alias_row_t;

endpackage

/* rtl/last_heard_mru_table_core.sv */
`timescale 1ns / 1ps

// Last-heard caller table with move-to-front order. One link-control frame is
// taken per transfer on the s_ side (opcode in s_tuser, frame bytes 2..8 in
// s_tdata) and one result describing the front entry leaves on the m_ side.
// Caller ID and talk group sit in one memory, the 32-byte aliases in a second
// one, both indexed by entry; the rank order is a register file. A voice
// header from a new caller goes through accept, a search that walks the ID
// memory one rank per cycle and ends at a hit or at the last rank, update,
// head read and finish; every other frame goes through accept, head read
// and finish only. One frame is worked on at a time; the next is taken
// while the previous result waits in the output register. No clearing pass
// is needed after reset: per-entry valid bits make unwritten entries read
// as zero.
module last_heard_mru_table_core
    import lhmru_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // payload[55:0]
    input  logic [S_USER_W-1:0] s_tuser,   // opcode[7:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    // head_id[23:0], head_talk_group[47:24], alias_bytes_0_7[111:48],
    // alias_bytes_8_15[175:112], alias_bytes_16_23[239:176],
    // alias_bytes_24_31[303:240]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser    // display_update[0], newly_added[1]
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_RANK = IW'(NUM_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END   = CW'(NUM_ENTRIES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Control state
    logic [2:0]             state_reg, state_next;
    id_t                    last_caller_reg, last_caller_next;
    logic [IW-1:0]          rank_reg [NUM_ENTRIES];
    logic [IW-1:0]          rank_next [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] idv_reg, idv_next;
    logic [NUM_ENTRIES-1:0] alv_reg, alv_next;
    logic [CW-1:0]          icnt_reg, icnt_next;
    logic                   pv_reg, pv_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Payload state
    logic [OP_W-1:0]        op_reg, op_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [IW-1:0]          scan_reg [NUM_ENTRIES];
    logic [IW-1:0]          scan_next [NUM_ENTRIES];
    logic [IW-1:0]          pipe_entry_reg, pipe_entry_next;
    logic [IW-1:0]          pipe_rank_reg, pipe_rank_next;
    logic                   pipe_idv_reg, pipe_idv_next;
    logic                   hit_reg, hit_next;
    logic [IW-1:0]          found_rank_reg, found_rank_next;
    logic [IW-1:0]          found_entry_reg, found_entry_next;
    logic                   rd_idv_reg, rd_idv_next;
    logic                   rd_alv_reg, rd_alv_next;
    logic                   disp_reg, disp_next;
    logic                   added_reg, added_next;
    logic [M_DATA_W-1:0]    out_data_reg, out_data_next;
    logic [M_USER_W-1:0]    out_user_reg, out_user_next;

    // Memory ports
    logic                   idtg_wr_en, idtg_rd_en;
    logic [IW-1:0]          idtg_wr_addr, idtg_rd_addr;
    logic [IDTG_W-1:0]      idtg_wr_data, idtg_rd_data;
    logic                   alias_wr_en, alias_rd_en;
    logic [IW-1:0]          alias_wr_addr, alias_rd_addr;
    alias_row_t             alias_wr_data, alias_rd_data;

    // Frame fields
    id_t                    frame_id;
    tg_t                    frame_tg;
    id_t                    cmp_id;
    id_t                    head_id;
    tg_t                    head_tg;
    alias_row_t             head_row;
    logic                   alias_written;

    lhmru_ram #(
        .WIDTH (IDTG_W),
        .DEPTH (NUM_ENTRIES)
    ) u_idtg_ram (
        .clk     (clk),
        .wr_en   (idtg_wr_en),
        .wr_addr (idtg_wr_addr),
        .wr_data (idtg_wr_data),
        .rd_en   (idtg_rd_en),
        .rd_addr (idtg_rd_addr),
        .rd_data (idtg_rd_data)
    );

    lhmru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ENTRIES)
    ) u_alias_ram (
        .clk     (clk),
        .wr_en   (alias_wr_en),
        .wr_addr (alias_wr_addr),
        .wr_data (alias_wr_data),
        .rd_en   (alias_rd_en),
        .rd_addr (alias_rd_addr),
        .rd_data (alias_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign frame_tg = payload_reg[47:24];
    assign frame_id = payload_reg[23:0];

    // Search compare: unwritten entries read as zero
    assign cmp_id = pipe_idv_reg ? idtg_rd_data[IDTG_W-1:TG_W] : '0;

    // Head entry as read back, with the alias block merged in
    always_comb
    begin
        head_id       = rd_idv_reg ? idtg_rd_data[IDTG_W-1:TG_W] : '0;
        head_tg       = rd_idv_reg ? idtg_rd_data[TG_W-1:0] : '0;
        head_row      = rd_alv_reg ? alias_rd_data : '0;
        alias_written = 1'b0;
        case (op_reg)
            OP_ALIAS_0:
            begin
                // six bytes 3..8 at offset 0
                if (head_row[255:248] == 8'h00)
                begin
                    head_row[255:208] = payload_reg[47:0];
                    alias_written     = 1'b1;
                end
            end
            OP_ALIAS_1:
            begin
                // seven bytes at offset 6
                if (head_row[207:200] == 8'h00)
                begin
                    head_row[207:152] = payload_reg;
                    alias_written     = 1'b1;
                end
            end
            OP_ALIAS_2:
            begin
                // offset 13
                if (head_row[151:144] == 8'h00)
                begin
                    head_row[151:96] = payload_reg;
                    alias_written    = 1'b1;
                end
            end
            OP_ALIAS_3:
            begin
                // offset 20
                if (head_row[95:88] == 8'h00)
                begin
                    head_row[95:40] = payload_reg;
                    alias_written   = 1'b1;
                end
            end
            default:
            begin
                alias_written = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        last_caller_next = last_caller_reg;
        rank_next        = rank_reg;
        idv_next         = idv_reg;
        alv_next         = alv_reg;
        icnt_next        = icnt_reg;
        pv_next          = pv_reg;
        m_tvalid_next    = m_tvalid_reg;
        op_next          = op_reg;
        payload_next     = payload_reg;
        scan_next        = scan_reg;
        pipe_entry_next  = pipe_entry_reg;
        pipe_rank_next   = pipe_rank_reg;
        pipe_idv_next    = pipe_idv_reg;
        hit_next         = hit_reg;
        found_rank_next  = found_rank_reg;
        found_entry_next = found_entry_reg;
        rd_idv_next      = rd_idv_reg;
        rd_alv_next      = rd_alv_reg;
        disp_next        = disp_reg;
        added_next       = added_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;

        idtg_wr_en    = 1'b0;
        idtg_wr_addr  = found_entry_reg;
        idtg_wr_data  = {frame_id, frame_tg};
        idtg_rd_en    = 1'b0;
        idtg_rd_addr  = rank_reg[0];
        alias_wr_en   = 1'b0;
        alias_wr_addr = rank_reg[0];
        alias_wr_data = head_row;
        alias_rd_en   = 1'b0;
        alias_rd_addr = rank_reg[0];

        // result register drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser;
                    payload_next = s_tdata;
                    disp_next    = 1'b0;
                    added_next   = 1'b0;
                    pv_next      = 1'b0;
                    icnt_next    = '0;
                    scan_next    = rank_reg;
                    if (s_tuser == OP_VOICE_HDR && s_tdata[23:0] != last_caller_reg)
                    begin
                        last_caller_next = s_tdata[23:0];
                        state_next       = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_SEARCH:
            begin
                // issue one read per cycle in rank order
                if (icnt_reg != CNT_END)
                begin
                    idtg_rd_en      = 1'b1;
                    idtg_rd_addr    = scan_reg[0];
                    pipe_entry_next = scan_reg[0];
                    pipe_rank_next  = icnt_reg[IW-1:0];
                    pipe_idv_next   = idv_reg[scan_reg[0]];
                    pv_next         = 1'b1;
                    icnt_next       = icnt_reg + 1'b1;
                    for (int i = 0; i < NUM_ENTRIES - 1; i++)
                    begin
                        scan_next[i] = scan_reg[i + 1];
                    end
                end
                else
                begin
                    pv_next = 1'b0;
                end
                // compare the entry read last cycle
                if (pv_reg)
                begin
                    if (cmp_id == frame_id)
                    begin
                        hit_next         = 1'b1;
                        found_rank_next  = pipe_rank_reg;
                        found_entry_next = pipe_entry_reg;
                        state_next       = ST_UPDATE;
                    end
                    else if (pipe_rank_reg == LAST_RANK)
                    begin
                        hit_next         = 1'b0;
                        found_rank_next  = LAST_RANK;
                        found_entry_next = rank_reg[NUM_ENTRIES - 1];
                        state_next       = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                idtg_wr_en                = 1'b1;
                idv_next[found_entry_reg] = 1'b1;
                disp_next                 = 1'b1;
                if (!hit_reg)
                begin
                    // reused entry: alias reads as zero until written
                    alv_next[found_entry_reg] = 1'b0;
                    added_next                = 1'b1;
                end
                // move to front
                rank_next[0] = found_entry_reg;
                for (int i = 1; i < NUM_ENTRIES; i++)
                begin
                    if (IW'(i) <= found_rank_reg)
                    begin
                        rank_next[i] = rank_reg[i - 1];
                    end
                end
                state_next = ST_READ;
            end

            ST_READ:
            begin
                idtg_rd_en  = 1'b1;
                alias_rd_en = 1'b1;
                rd_idv_next = idv_reg[rank_reg[0]];
                rd_alv_next = alv_reg[rank_reg[0]];
                state_next  = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (alias_written)
                    begin
                        alias_wr_en           = 1'b1;
                        alv_next[rank_reg[0]] = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    out_data_next = {head_row[63:0], head_row[127:64],
                                     head_row[191:128], head_row[255:192],
                                     head_tg, head_id};
                    out_user_next = {added_reg, disp_reg | alias_written};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_caller_reg <= '0;
            idv_reg         <= '0;
            alv_reg         <= '0;
            icnt_reg        <= '0;
            pv_reg          <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                rank_reg[i] <= IW'(i);
            end
        end
        else
        begin
            state_reg       <= state_next;
            last_caller_reg <= last_caller_next;
            idv_reg         <= idv_next;
            alv_reg         <= alv_next;
            icnt_reg        <= icnt_next;
            pv_reg          <= pv_next;
            m_tvalid_reg    <= m_tvalid_next;
            rank_reg        <= rank_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        payload_reg     <= payload_next;
        scan_reg        <= scan_next;
        pipe_entry_reg  <= pipe_entry_next;
        pipe_rank_reg   <= pipe_rank_next;
        pipe_idv_reg    <= pipe_idv_next;
        hit_reg         <= hit_next;
        found_rank_reg  <= found_rank_next;
        found_entry_reg <= found_entry_next;
        rd_idv_reg      <= rd_idv_next;
        rd_alv_reg      <= rd_alv_next;
        disp_reg        <= disp_next;
        added_reg       <= added_next;
        out_data_reg    <= out_data_next;
        out_user_reg    <= out_user_next;
    end

endmodule

/* rtl/lhmru_ram.sv */
`timescale 1ns / 1ps

module lhmru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; data holds without rd_en
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lhmru_checker.sv */
`timescale 1ns / 1ps

`include "last_heard_mru_table_core_macros.svh"

module lhmru_checker
    import lhmru_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // A stalled result holds
    `LHMRU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One frame in work at a time
    `LHMRU_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "frame taken while busy")

    // A new caller always updates the display
    `LHMRU_ASSERT_IMP(a_added_disp, m_tvalid && m_tuser[1], m_tuser[0], "newly added without display update")

    // A reused entry starts with an empty alias
    `LHMRU_ASSERT_IMP(a_added_alias_clear, m_tvalid && m_tuser[1], m_tdata[M_DATA_W-1:ID_W+TG_W] == '0, "new entry alias not cleared")

endmodule

bind last_heard_mru_table_core lhmru_checker u_lhmru_checker (.*);
